>>> design/u16to8_pkg.sv
`default_nettype none
package u16to8_pkg;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_text;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  utf8_byte;
    logic [31:0] byte_offset;
    logic        is_sentinel;
    logic        last;
  } out_item_t;

  // state update and bookkeeping for the result now being issued
  typedef struct packed {
    logic       is_byte;
    logic       pend_nxt;
    logic [9:0] held_nxt;
  } dec_ctrl_t;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_OFFSET = 1'b1;

  localparam logic [15:0] UNIT_HIGH_FIRST = 16'hD800;
  localparam logic [15:0] UNIT_LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] UNIT_SUR_END    = 16'hE000;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
  localparam logic [15:0] CP_TWO_BYTE    = 16'h0080;
  localparam logic [15:0] CP_THREE_BYTE  = 16'h0800;

  localparam logic [7:0] LEAD2     = 8'hC0;
  localparam logic [7:0] LEAD3     = 8'hE0;
  localparam logic [7:0] LEAD4     = 8'hF0;
  localparam logic [7:0] CONT      = 8'h80;
  localparam logic [5:0] CONT_MASK = 6'h3F;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1    = 3'd1;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // Byte k of the UTF-8 form of cp, encoded in len bytes.
  function automatic logic [7:0] utf8_byte_at(input logic [20:0] cp,
                                               input logic [2:0]  len,
                                               input logic [1:0]  k);
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] b;
    c0 = CONT | {2'b00, cp[5:0] & CONT_MASK};
    c1 = CONT | {2'b00, cp[11:6] & CONT_MASK};
    c2 = CONT | {2'b00, cp[17:12] & CONT_MASK};
    b  = 8'h00;
    unique case (len)
      LEN_1: b = {1'b0, cp[6:0]};
      LEN_2: b = (k == 2'd0) ? (LEAD2 | {3'b000, cp[10:6]}) : c0;
      LEN_3: begin
        unique case (k)
          2'd0:    b = LEAD3 | {4'b0000, cp[15:12]};
          2'd1:    b = c1;
          default: b = c0;
        endcase
      end
      LEN_4: begin
        unique case (k)
          2'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
          2'd1:    b = c2;
          2'd2:    b = c1;
          default: b = c0;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> design/u16to8_unit_dec.sv
`default_nettype none
module u16to8_unit_dec (
  input  u16to8_pkg::in_item_t  item,
  input  logic                  pend,
  input  logic [9:0]            held,
  input  logic [31:0]           byte_count,
  input  logic [2:0]            idx,
  output u16to8_pkg::out_item_t res,
  output u16to8_pkg::dec_ctrl_t ctrl
);
  import u16to8_pkg::*;

  logic        eot;
  logic        is_high;
  logic        is_low;
  logic        pair;
  logic        pre;
  logic [2:0]  pre_len;
  logic [20:0] tail_cp;
  logic [2:0]  tail_len;
  logic [1:0]  tail_k;
  logic [7:0]  fffd_byte;

  assign eot     = item.end_of_text;
  assign is_high = (item.code_unit >= UNIT_HIGH_FIRST) && (item.code_unit < UNIT_LOW_FIRST);
  assign is_low  = (item.code_unit >= UNIT_LOW_FIRST) && (item.code_unit < UNIT_SUR_END);
  assign pair    = !eot && pend && is_low;
  // a held high that is not completed flushes as a replacement char first
  assign pre     = pend && !pair;
  assign pre_len = pre ? LEN_3 : LEN_NONE;

  always_comb begin
    tail_cp  = {5'b00000, item.code_unit};
    tail_len = LEN_3;
    priority if (eot) begin
      tail_len = LEN_NONE;
    end else if (pair) begin
      tail_cp  = CP_SUPP_BASE + {1'b0, held, item.code_unit[9:0]};
      tail_len = LEN_4;
    end else if (is_high) begin
      tail_len = LEN_NONE;
    end else if (is_low) begin
      tail_cp  = CP_REPLACEMENT;
      tail_len = LEN_3;
    end else if (item.code_unit < CP_TWO_BYTE) begin
      tail_len = LEN_1;
    end else if (item.code_unit < CP_THREE_BYTE) begin
      tail_len = LEN_2;
    end else begin
      tail_len = LEN_3;
    end
  end

  assign tail_k    = idx[1:0] - pre_len[1:0] - 2'd1;
  assign fffd_byte = utf8_byte_at(CP_REPLACEMENT, LEN_3, idx[1:0]);

  always_comb begin
    res             = '0;
    res.last        = (idx == pre_len + tail_len);
    ctrl.is_byte    = 1'b1;
    // hold a fresh high surrogate, drop everything else
    ctrl.pend_nxt   = !eot && is_high && !pair;
    ctrl.held_nxt   = ctrl.pend_nxt ? item.code_unit[9:0] : 10'd0;
    priority if (idx < pre_len) begin
      res.kind      = KIND_BYTE;
      res.utf8_byte = fffd_byte;
    end else if (idx == pre_len) begin
      res.kind        = KIND_OFFSET;
      res.byte_offset = byte_count;
      res.is_sentinel = eot;
      ctrl.is_byte    = 1'b0;
    end else begin
      res.kind      = KIND_BYTE;
      res.utf8_byte = utf8_byte_at(tail_cp, tail_len, tail_k);
    end
  end

endmodule
`default_nettype wire

>>> design/u16to8_out_stage.sv
`default_nettype none
module u16to8_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ld_valid,
  input  u16to8_pkg::out_item_t ld_item,
  output logic                  slot_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u16to8_pkg::out_item_t out_item
);
  import u16to8_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  assign slot_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (ld_valid) begin
      valid_nxt = 1'b1;
    end else if (slot_free) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid) begin
      item_r <= ld_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

>>> design/utf16_to_utf8_with_offsets_top.sv
// An accepted item is held in item_r; its results reach out_item via the output register.
// Throughput: one result per cycle while out_stall is low, set by the single output register;
//   an item has 1 to 7 results (offset entry plus up to six bytes).
// A new item is taken in the cycle its last result moves to the output register.
// Reset (rst_n low, synchronous) drops any item in flight, clears the held high
//   surrogate and the byte counter, and empties the output register.
`default_nettype none
module utf16_to_utf8_with_offsets_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  u16to8_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u16to8_pkg::out_item_t out_item
);
  import u16to8_pkg::*;

  // current item and the index of the result it issues next
  in_item_t    item_r;
  logic        item_v_r;
  logic        item_v_nxt;
  logic [2:0]  idx_r;
  logic [2:0]  idx_nxt;

  // text state: held high surrogate and running byte count
  logic        pend_r;
  logic        pend_nxt;
  logic [9:0]  held_r;
  logic [9:0]  held_nxt;
  logic [31:0] cnt_r;
  logic [31:0] cnt_nxt;

  out_item_t   res;
  dec_ctrl_t   ctrl;
  logic        slot_free;
  logic        fire;
  logic        done;
  logic        accept;

  // The held surrogate only changes once the item is complete, so every result
  // of the item is decoded from the same view of it; the count moves per byte.
  u16to8_unit_dec u_dec (
    .item       (item_r),
    .pend       (pend_r),
    .held       (held_r),
    .byte_count (cnt_r),
    .idx        (idx_r),
    .res        (res),
    .ctrl       (ctrl)
  );

  u16to8_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (fire),
    .ld_item   (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // issue one result whenever the output register has room
  assign fire     = item_v_r && slot_free;
  assign done     = fire && res.last;
  assign in_stall = item_v_r && !done;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    item_v_nxt = item_v_r;
    idx_nxt    = idx_r;
    pend_nxt   = pend_r;
    held_nxt   = held_r;
    cnt_nxt    = cnt_r;
    if (fire && ctrl.is_byte) begin
      cnt_nxt = cnt_r + 32'd1;
    end
    if (fire) begin
      idx_nxt = idx_r + 3'd1;
    end
    if (done) begin
      item_v_nxt = 1'b0;
      pend_nxt   = ctrl.pend_nxt;
      held_nxt   = ctrl.held_nxt;
      // the end of text restarts the counter after the sentinel
      if (item_r.end_of_text) begin
        cnt_nxt = 32'd0;
      end
    end
    if (accept) begin
      item_v_nxt = 1'b1;
      idx_nxt    = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      idx_r    <= 3'd0;
      pend_r   <= 1'b0;
      held_r   <= 10'd0;
      cnt_r    <= 32'd0;
    end else begin
      item_v_r <= item_v_nxt;
      idx_r    <= idx_nxt;
      pend_r   <= pend_nxt;
      held_r   <= held_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  // no item ever issues more than seven results
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    item_v_r |-> idx_r <= 3'd6)
    else $error("result index past the longest item");

  // after a sentinel the text state is clean
  a_eot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (done && item_r.end_of_text) |=> (cnt_r == 32'd0) && !pend_r)
    else $error("state not cleared at end of text");

  // held bits are zero whenever nothing is held
  a_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_r |-> held_r == 10'd0)
    else $error("held surrogate bits without a pending high");

  // a sentinel is always an offset entry and closes its item
  a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.is_sentinel) |-> (out_item.kind == KIND_OFFSET) && out_item.last)
    else $error("malformed sentinel result");

endmodule
`default_nettype wire
